FILE: rtl/mau_pkg.sv
// Types and constants shared by the modular arithmetic unit.
package mau_pkg;

	localparam int MOD_W = 31;
	localparam int MAG_W = 64;
	localparam int EXP_W = 63;
	localparam int CNT_W = 6;

	localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1000000007;

	// Register index of the modulus, taken from the word address.
	localparam logic REG_MODULUS = 1'b0;

	// Operation codes carried by the mode field.
	localparam logic [2:0] MODE_RED = 3'd0;
	localparam logic [2:0] MODE_ADD = 3'd1;
	localparam logic [2:0] MODE_SUB = 3'd2;
	localparam logic [2:0] MODE_MUL = 3'd3;
	localparam logic [2:0] MODE_NEG = 3'd4;
	localparam logic [2:0] MODE_POW = 3'd5;
	localparam logic [2:0] MODE_INV = 3'd6;
	localparam logic [2:0] MODE_DIV = 3'd7;

	// Step counts of the bit-serial passes, as the last counter value.
	localparam logic [CNT_W-1:0] RED_LAST = 6'd63;
	localparam logic [CNT_W-1:0] MUL_LAST = 6'd30;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RED_A,
		ST_RED_B,
		ST_DISPATCH,
		ST_POW,
		ST_MUL,
		ST_FINISH
	} state_t;

	// Where the product of a modular multiply is written back.
	typedef enum logic [1:0] {
		MK_ACC,
		MK_SQ,
		MK_FINAL
	} mul_kind_t;

	// Request to the shared modular step unit.
	typedef struct packed {
		logic             dbl;
		logic [MOD_W-1:0] acc;
		logic [MOD_W-1:0] addend;
	} step_req_t;

endpackage

FILE: rtl/mau_step.sv
// Shared modular step unit: (2*acc or acc) plus addend, reduced below the modulus.
module mau_step (
	input  mau_pkg::step_req_t          req,
	input  logic [mau_pkg::MOD_W-1:0]   modulus,
	output logic [mau_pkg::MOD_W-1:0]   r
);
	import mau_pkg::*;

	logic [MOD_W+1:0] sum;
	logic [MOD_W+1:0] m1;
	logic [MOD_W+1:0] m2;

	// Both inputs lie below the modulus, so the sum stays below three moduli.
	always_comb begin
		m1  = {2'b00, modulus};
		m2  = {1'b0, modulus, 1'b0};
		sum = (req.dbl ? {1'b0, req.acc, 1'b0} : {2'b00, req.acc}) + {2'b00, req.addend};
		if (sum >= m2) begin
			r = MOD_W'(sum - m2);
		end else if (sum >= m1) begin
			r = MOD_W'(sum - m1);
		end else begin
			r = sum[MOD_W-1:0];
		end
	end

endmodule

FILE: rtl/mau_cfg.sv
// Configuration register file holding the modulus behind an APB-style port.
module mau_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [2:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output logic [mau_pkg::MOD_W-1:0]   modulus
);
	import mau_pkg::*;

	logic [MOD_W-1:0] modulus_q;
	logic             wr_en;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && (paddr[2] == REG_MODULUS);
	assign modulus = modulus_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MODULUS_RESET;
		end else if (wr_en) begin
			modulus_q <= pwdata[MOD_W-1:0];
		end
	end

	always_comb begin
		if (paddr[2] == REG_MODULUS) begin
			prdata = {1'b0, modulus_q};
		end else begin
			prdata = '0;
		end
	end

endmodule

FILE: rtl/modular_arithmetic_unit.sv
// Modular arithmetic unit over a configured modulus. Each item carries a mode, two signed
// 64-bit operands and an exponent, and gives exactly one residue in 0 to modulus-1. The
// operands are first reduced bit-serially, one bit per cycle, operand_a in every mode and
// operand_b in the add, subtract, multiply and divide modes. All arithmetic runs through
// one shared modular step unit (a double, an add and a reduction by up to two subtractions
// each cycle), and every modular multiply is a shift-and-add pass over the multiplier bits,
// set up by a step of the power loop in the power modes. An item is accepted, reduced,
// dispatched, worked on and finished, in that order. Power does one multiply per set
// exponent bit and one squaring for every bit up to and including the top set bit; inverse
// uses the exponent modulus-2 and divide adds the reduction of operand_b and one more
// multiply. The block takes one item at a time, but a finished result waits in the output
// register while the next item is already accepted. A modulus below two gives a result of
// zero for every mode. The modulus sits at byte address 0 of the configuration port and may
// be written only while the block is idle.
module modular_arithmetic_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	// Input items.
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [2:0]                  mode,
	input  logic signed [63:0]          operand_a,
	input  logic signed [63:0]          operand_b,
	input  logic [62:0]                 exponent,
	// Result items.
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [mau_pkg::MOD_W-1:0]   result,
	// Configuration port.
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [2:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import mau_pkg::*;

	// Sequencer state and counter.
	state_t           state_q;
	state_t           state_d;
	logic [CNT_W-1:0] cnt_q;

	// Item registers.
	logic [2:0]       mode_q;
	logic [EXP_W-1:0] exp_q;
	logic [MAG_W-1:0] mag_q;
	logic [MAG_W-1:0] bmag_q;
	logic             nega_q;
	logic             negb_q;
	logic [MOD_W-1:0] a_q;
	logic [MOD_W-1:0] b_q;

	// Working registers of the multiply and power loops.
	logic [MOD_W-1:0] acc_q;
	logic [MOD_W-1:0] mx_q;
	logic [MOD_W-1:0] my_q;
	logic [MOD_W-1:0] pacc_q;
	logic [MOD_W-1:0] sq_q;
	mul_kind_t        kind_q;

	// Finished value and output register.
	logic [MOD_W-1:0] res_q;
	logic [MOD_W-1:0] result_q;
	logic             out_valid_q;

	logic [MOD_W-1:0] modulus;
	step_req_t        step_req;
	logic [MOD_W-1:0] step_r;
	logic [MOD_W-1:0] red_fix;
	logic [MOD_W-1:0] nega_res;
	logic [MOD_W-1:0] negb_res;
	logic [MAG_W-1:0] mag_a_in;
	logic [MAG_W-1:0] mag_b_in;
	logic             uses_b;
	logic             out_free;
	logic             accept;

	mau_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.modulus (modulus)
	);

	mau_step u_step (
		.req     (step_req),
		.modulus (modulus),
		.r       (step_r)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign result    = result_q;
	assign out_free  = !out_valid_q || out_ready;

	// Magnitudes of the signed operands; the most negative value maps to 2^63 unchanged.
	assign mag_a_in = operand_a[63] ? (64'd0 - operand_a) : operand_a;
	assign mag_b_in = operand_b[63] ? (64'd0 - operand_b) : operand_b;

	// Only these modes need operand_b reduced.
	assign uses_b = (mode_q inside {MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV});

	// A negative operand with a non-zero residue becomes modulus minus that residue.
	always_comb begin
		nega_res = (a_q == '0) ? '0 : (modulus - a_q);
		negb_res = (b_q == '0) ? '0 : (modulus - b_q);
		if (((state_q == ST_RED_A) ? nega_q : negb_q) && (step_r != '0)) begin
			red_fix = modulus - step_r;
		end else begin
			red_fix = step_r;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (modulus < 31'd2) ? ST_FINISH : ST_RED_A;
				end
			end
			ST_RED_A: begin
				if (cnt_q == '0) begin
					state_d = uses_b ? ST_RED_B : ST_DISPATCH;
				end
			end
			ST_RED_B: begin
				if (cnt_q == '0) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (mode_q)
					MODE_MUL:                     state_d = ST_MUL;
					MODE_POW, MODE_INV, MODE_DIV: state_d = ST_POW;
					default:                      state_d = ST_FINISH;
				endcase
			end
			ST_POW: begin
				if (exp_q == '0) begin
					state_d = (mode_q == MODE_DIV) ? ST_MUL : ST_FINISH;
				end else begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				if (cnt_q == '0) begin
					state_d = (kind_q == MK_FINAL) ? ST_FINISH : ST_POW;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Request to the shared step unit for the current state.
	always_comb begin
		step_req = '0;
		case (state_q)
			ST_RED_A, ST_RED_B: begin
				step_req.dbl    = 1'b1;
				step_req.acc    = acc_q;
				step_req.addend = {{(MOD_W-1){1'b0}}, mag_q[MAG_W-1]};
			end
			ST_MUL: begin
				step_req.dbl    = 1'b1;
				step_req.acc    = acc_q;
				step_req.addend = my_q[MOD_W-1] ? mx_q : '0;
			end
			ST_DISPATCH: begin
				step_req.dbl = 1'b0;
				case (mode_q)
					MODE_ADD: begin
						step_req.acc    = a_q;
						step_req.addend = b_q;
					end
					MODE_SUB: begin
						step_req.acc    = a_q;
						step_req.addend = negb_res;
					end
					MODE_NEG: begin
						step_req.acc    = '0;
						step_req.addend = nega_res;
					end
					default: begin
						step_req.acc    = a_q;
						step_req.addend = '0;
					end
				endcase
			end
			default: step_req = '0;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cnt_q <= RED_LAST;
					end
				end
				ST_RED_A: begin
					cnt_q <= (cnt_q == '0) ? RED_LAST : (cnt_q - 6'd1);
				end
				ST_RED_B, ST_MUL: begin
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				ST_DISPATCH, ST_POW: begin
					cnt_q <= MUL_LAST;
				end
				default: cnt_q <= cnt_q;
			endcase
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					mode_q <= mode;
					exp_q  <= exponent;
					nega_q <= operand_a[63];
					negb_q <= operand_b[63];
					mag_q  <= mag_a_in;
					bmag_q <= mag_b_in;
					acc_q  <= '0;
					res_q  <= '0;
				end
			end
			ST_RED_A: begin
				acc_q <= step_r;
				mag_q <= mag_q << 1;
				if (cnt_q == '0) begin
					a_q   <= red_fix;
					acc_q <= '0;
					mag_q <= bmag_q;
				end
			end
			ST_RED_B: begin
				acc_q <= step_r;
				mag_q <= mag_q << 1;
				if (cnt_q == '0) begin
					b_q <= red_fix;
				end
			end
			ST_DISPATCH: begin
				case (mode_q)
					MODE_MUL: begin
						mx_q   <= a_q;
						my_q   <= b_q;
						acc_q  <= '0;
						kind_q <= MK_FINAL;
					end
					MODE_POW: begin
						pacc_q <= 31'd1;
						sq_q   <= a_q;
					end
					MODE_INV: begin
						pacc_q <= 31'd1;
						sq_q   <= a_q;
						exp_q  <= {{(EXP_W-MOD_W){1'b0}}, modulus - 31'd2};
					end
					MODE_DIV: begin
						pacc_q <= 31'd1;
						sq_q   <= b_q;
						exp_q  <= {{(EXP_W-MOD_W){1'b0}}, modulus - 31'd2};
					end
					default: res_q <= step_r;
				endcase
			end
			ST_POW: begin
				acc_q <= '0;
				if (exp_q == '0) begin
					// Power done; divide still multiplies the inverse by a.
					res_q  <= pacc_q;
					mx_q   <= a_q;
					my_q   <= pacc_q;
					kind_q <= MK_FINAL;
				end else if (exp_q[0]) begin
					mx_q     <= sq_q;
					my_q     <= pacc_q;
					kind_q   <= MK_ACC;
					exp_q[0] <= 1'b0;
				end else begin
					mx_q   <= sq_q;
					my_q   <= sq_q;
					kind_q <= MK_SQ;
					exp_q  <= exp_q >> 1;
				end
			end
			ST_MUL: begin
				acc_q <= step_r;
				my_q  <= my_q << 1;
				if (cnt_q == '0) begin
					case (kind_q)
						MK_ACC:  pacc_q <= step_r;
						MK_SQ:   sq_q   <= step_r;
						default: res_q  <= step_r;
					endcase
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					result_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	// A delivered residue lies below the modulus.
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && modulus >= 31'd2 |-> result < modulus)
		else $error("result not below the modulus");

	// An accepted item always starts work in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q != ST_IDLE)
		else $error("accepted item did not start");

	// The power loop only ever holds reduced values.
	a_pow_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_POW && modulus >= 31'd2 |-> pacc_q < modulus && sq_q < modulus)
		else $error("power loop operand not reduced");

	// Operand reduction steps one bit per cycle.
	a_red_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RED_A && cnt_q != '0 |=> state_q == ST_RED_A && cnt_q == $past(cnt_q) - 6'd1)
		else $error("reduction counter out of step");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the modular arithmetic unit: directed table, then random items.
`timescale 1ns / 100ps

module testbench;
	import mau_pkg::*;

	// Run limit in clock cycles. The slowest legal run is a full 63-bit power on every item
	// plus both sides' longest waits, for roughly 1750 items; the limit is several times that.
	localparam int unsigned CYCLE_LIMIT = 32'd30_000_000;

	// Byte address of the modulus register on the configuration port.
	localparam logic [2:0] MODULUS_ADDR = {REG_MODULUS, 2'b00};

	localparam logic [63:0] S64_MIN   = 64'h8000_0000_0000_0000;
	localparam logic [63:0] S64_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] MINUS_ONE = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [62:0] EXP_MAX   = 63'h7FFF_FFFF_FFFF_FFFF;

	localparam int unsigned PHASES = 13;

	// One row of the directed table. Where typed is set, res holds the residue that can be
	// read straight off the arithmetic; otherwise the predictor supplies it.
	typedef struct packed {
		logic [2:0]       op;
		logic [63:0]      a;
		logic [63:0]      b;
		logic [EXP_W-1:0] e;
		logic             typed;
		logic [MOD_W-1:0] res;
	} stim_row_t;

	// Residue still owed by the block, with the mode of the item that caused it.
	typedef struct packed {
		logic [2:0]       op;
		logic [MOD_W-1:0] residue;
	} residue_due_t;

	// The directed rows all run at the reset modulus, 1000000007.
	localparam stim_row_t DIRECTED_ROWS [0:25] = '{
		'{MODE_RED, 64'd0,          64'd0,     63'd0,   1'b1, 31'd0},
		'{MODE_RED, 64'd1000000007, 64'd0,     63'd0,   1'b1, 31'd0},
		'{MODE_RED, MINUS_ONE,      64'd0,     63'd0,   1'b1, 31'd1000000006},
		'{MODE_RED, S64_MIN,        64'd0,     63'd0,   1'b0, 31'd0},
		'{MODE_RED, S64_MAX,        S64_MIN,   EXP_MAX, 1'b0, 31'd0},
		'{MODE_ADD, 64'd1000000006, 64'd1,     63'd0,   1'b1, 31'd0},
		'{MODE_ADD, MINUS_ONE,      MINUS_ONE, 63'd0,   1'b1, 31'd1000000005},
		'{MODE_SUB, 64'd0,          64'd1,     63'd0,   1'b1, 31'd1000000006},
		'{MODE_SUB, 64'd5,          64'd3,     63'd0,   1'b1, 31'd2},
		'{MODE_SUB, S64_MIN,        S64_MAX,   63'd0,   1'b0, 31'd0},
		'{MODE_MUL, MINUS_ONE,      MINUS_ONE, 63'd0,   1'b1, 31'd1},
		'{MODE_MUL, S64_MAX,        S64_MIN,   63'd0,   1'b0, 31'd0},
		'{MODE_NEG, 64'd0,          64'd0,     63'd0,   1'b1, 31'd0},
		'{MODE_NEG, 64'd1,          64'd0,     63'd0,   1'b1, 31'd1000000006},
		'{MODE_NEG, S64_MIN,        64'd0,     63'd0,   1'b0, 31'd0},
		'{MODE_POW, 64'd2,          64'd0,     63'd0,   1'b1, 31'd1},
		'{MODE_POW, 64'd0,          64'd0,     63'd0,   1'b1, 31'd1},
		'{MODE_POW, 64'd2,          64'd0,     63'd10,  1'b1, 31'd1024},
		'{MODE_POW, 64'd3,          64'd0,     EXP_MAX, 1'b0, 31'd0},
		'{MODE_INV, 64'd1,          64'd0,     63'd0,   1'b1, 31'd1},
		'{MODE_INV, 64'd0,          64'd0,     63'd0,   1'b1, 31'd0},
		'{MODE_INV, 64'd2,          64'd0,     63'd0,   1'b1, 31'd500000004},
		'{MODE_INV, MINUS_ONE,      64'd0,     63'd0,   1'b1, 31'd1000000006},
		'{MODE_DIV, 64'd6,          64'd3,     63'd0,   1'b1, 31'd2},
		'{MODE_DIV, 64'd1,          64'd0,     63'd0,   1'b1, 31'd0},
		'{MODE_DIV, S64_MIN,        S64_MAX,   63'd0,   1'b0, 31'd0}
	};

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    in_valid  = 1'b0;
	logic                    in_ready;
	logic [2:0]              mode      = MODE_RED;
	logic signed [63:0]      operand_a = '0;
	logic signed [63:0]      operand_b = '0;
	logic [EXP_W-1:0]        exponent  = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [MOD_W-1:0]        result;
	logic                    psel      = 1'b0;
	logic                    penable   = 1'b0;
	logic                    pwrite    = 1'b0;
	logic [2:0]              paddr     = '0;
	logic [31:0]             pwdata    = '0;
	logic [31:0]             prdata;
	logic                    pready;

	// The testbench's own copy of the modulus register, updated on every write.
	logic [MOD_W-1:0]        cur_modulus;

	// Residues owed by the block, oldest first.
	residue_due_t            pending_residues [$];

	int unsigned             fail_count    = 0;
	int unsigned             items_sent    = 0;
	int unsigned             results_seen  = 0;
	int unsigned             cycle_count   = 0;
	int unsigned             mode_count [8];
	bit                      sender_calm   = 1'b0;

	logic [31:0]             plan_modulus [PHASES];
	int unsigned             plan_items [PHASES];

	modular_arithmetic_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.exponent  (exponent),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result    (result),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------------------------
	// Prediction.
	// ------------------------------------------------------------------------------------

	// Brings a two's complement operand into 0 .. m-1. A negative operand takes the residue
	// of its magnitude away from m, unless that residue is already zero.
	function automatic longint unsigned fold_signed(input logic [63:0] raw,
			input longint unsigned m);
		longint unsigned mag;
		longint unsigned r;
		mag = raw[63] ? (64'd0 - raw) : raw;
		r = mag % m;
		if (raw[63] && r != 0)
			r = m - r;
		return r;
	endfunction

	// Right-to-left square and multiply. Operands stay below 2^31, so every product fits
	// comfortably in 64 bits.
	function automatic longint unsigned power_residue(input longint unsigned base,
			input longint unsigned e, input longint unsigned m);
		longint unsigned acc;
		longint unsigned sq;
		acc = 1 % m;
		sq = base;
		while (e != 0) begin
			if ((e & 1) != 0)
				acc = (acc * sq) % m;
			sq = (sq * sq) % m;
			e = e >> 1;
		end
		return acc;
	endfunction

	// Residue that one item must give under modulus m_reg.
	function automatic logic [MOD_W-1:0] predict_residue(input logic [2:0] op,
			input logic [63:0] a_raw, input logic [63:0] b_raw, input logic [EXP_W-1:0] e,
			input logic [MOD_W-1:0] m_reg);
		longint unsigned m;
		longint unsigned a;
		longint unsigned b;
		longint unsigned r;
		m = 64'(m_reg);
		// A modulus of 0 or 1 lies outside the useful range and forces a zero result.
		if (m < 2)
			return '0;
		a = fold_signed(a_raw, m);
		b = fold_signed(b_raw, m);
		case (op)
			MODE_RED: r = a;
			MODE_ADD: begin
				r = a + b;
				if (r >= m)
					r = r - m;
			end
			MODE_SUB: r = (a >= b) ? a - b : a + m - b;
			MODE_MUL: r = (a * b) % m;
			MODE_NEG: r = (m - a) % m;
			MODE_POW: r = power_residue(a, 64'(e), m);
			// Fermat inverse: the rule is applied even to zero and to composite moduli.
			MODE_INV: r = power_residue(a, m - 2, m);
			default:  r = (a * power_residue(b, m - 2, m)) % m;
		endcase
		return r[MOD_W-1:0];
	endfunction

	// ------------------------------------------------------------------------------------
	// Random values.
	// ------------------------------------------------------------------------------------

	// Operands are drawn from several families so that both signs, the 64-bit extremes,
	// values on and around multiples of the modulus, and every bit of the field occur.
	function automatic logic [63:0] pick_operand(input logic [MOD_W-1:0] m_reg);
		logic [31:0] hi;
		logic [31:0] lo;
		logic [63:0] m;
		logic [63:0] near;
		hi = $urandom;
		lo = $urandom;
		m = 64'(m_reg);
		near = m * 64'($urandom_range(3)) + 64'($urandom_range(4)) - 64'd2;
		case ($urandom_range(7))
			0: return {hi, lo};
			1: return 64'($urandom_range(1000));
			2: return 64'd0 - 64'($urandom_range(1000));
			3: return near;
			4: case ($urandom_range(4))
				0: return S64_MIN;
				1: return S64_MAX;
				2: return MINUS_ONE;
				3: return S64_MIN + 64'd1;
				default: return 64'd0;
			endcase
			5: return (m == 0) ? 64'(lo) : 64'(lo) % m;
			6: return 64'd0 - near;
			default: return {hi, lo} >> $urandom_range(63);
		endcase
	endfunction

	// Exponents are kept short most of the time, since each bit costs the block a squaring and
	// each set bit one more multiply; a full-width exponent turns up now and then.
	function automatic logic [EXP_W-1:0] pick_exponent(input logic [MOD_W-1:0] m_reg);
		logic [31:0] hi;
		logic [31:0] lo;
		hi = $urandom;
		lo = $urandom;
		case ($urandom_range(15))
			0: return '0;
			1: return {hi[30:0], lo};
			2: return 63'(m_reg) - 63'($urandom_range(2));
			default: return 63'(lo & ((32'd1 << $urandom_range(20, 1)) - 32'd1));
		endcase
	endfunction

	// ------------------------------------------------------------------------------------
	// Failure reporting, shared by every check.
	// ------------------------------------------------------------------------------------

	task automatic note_failure(input string what, input longint unsigned want,
			input longint unsigned got);
		fail_count++;
		if (fail_count <= 10)
			$display("[%0t] MISMATCH %s: expected %0d, got %0d", $realtime, what, want, got);
	endtask

	// ------------------------------------------------------------------------------------
	// Configuration port. Both tasks start just after a rising edge with the port idle.
	// ------------------------------------------------------------------------------------

	task automatic read_modulus(output logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= MODULUS_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		// Sampled as it stood during the access cycle.
		value = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic write_modulus(input logic [31:0] value);
		logic [31:0] readback;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= MODULUS_ADDR;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		// Bit 31 of the write data has no home in a 31-bit register.
		cur_modulus = value[MOD_W-1:0];
		// The port goes idle before the read-back starts.
		@(posedge clk);
		read_modulus(readback);
		if (readback !== {1'b0, cur_modulus})
			note_failure("modulus read-back", {1'b0, cur_modulus}, readback);
	endtask

	// ------------------------------------------------------------------------------------
	// Input side.
	// ------------------------------------------------------------------------------------

	// Offers one item, after a random gap, and holds it until the block takes it. The owed
	// residue is queued at the edge of acceptance, under the modulus then in force.
	task automatic offer_item(input logic [2:0] op, input logic [63:0] a,
			input logic [63:0] b, input logic [EXP_W-1:0] e, input bit typed,
			input logic [MOD_W-1:0] typed_res);
		int unsigned gap;
		residue_due_t due;
		// Every so often a stretch of back-to-back items, with no gaps at all.
		if (items_sent % 64 == 0)
			sender_calm = ($urandom_range(3) == 0);
		gap = sender_calm ? 0 : $urandom_range(15);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		mode      <= op;
		operand_a <= a;
		operand_b <= b;
		exponent  <= e;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		due.op = op;
		due.residue = typed ? typed_res : predict_residue(op, a, b, e, cur_modulus);
		pending_residues.push_back(due);
		items_sent++;
		mode_count[op]++;
	endtask

	// Stops offering items and waits until every owed residue has been taken, then gives the
	// block time to fall back to idle. Configuration writes follow this.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_residues.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------------------
	// Output side: a random stall before each result, with calm stretches in between.
	// ------------------------------------------------------------------------------------

	initial begin
		int unsigned stall;
		int unsigned served;
		bit calm;
		served = 0;
		calm = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (served % 48 == 0)
				calm = ($urandom_range(3) == 0);
			stall = calm ? 0 : $urandom_range(15);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			served++;
		end
	end

	// Every accepted result is compared with the oldest residue still owed.
	always @(posedge clk) begin
		residue_due_t due;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_residues.size() == 0) begin
				note_failure("result with nothing owed", 0, result);
			end else begin
				due = pending_residues.pop_front();
				if (result !== due.residue)
					note_failure($sformatf("result of mode %0d", due.op), due.residue,
						result);
			end
		end
	end

	// Hard stop if the block hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Run limit of %0d cycles reached with %0d results still owed",
				CYCLE_LIMIT, pending_residues.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// ------------------------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------------------------

	initial begin
		logic [31:0] readback;
		logic [2:0]  op;
		for (int i = 0; i < 8; i++)
			mode_count[i] = 0;

		// The plan of modulus settings: the reset value first, then both ends of the range,
		// small and large primes, a composite, the two values below the useful range, a write
		// with bit 31 set, two random values, and finally the reset value written back.
		plan_modulus = '{{1'b0, MODULUS_RESET}, 32'd2, 32'd3, 32'h7FFF_FFFF, 32'd65521,
			32'd1000003, 32'd91, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd1000000007};
		plan_modulus[10] = $urandom_range(32'h7FFF_FFFF, 32'h0100_0000);
		plan_modulus[11] = $urandom_range(1000, 4);
		plan_items = '{200, 120, 120, 200, 150, 150, 120, 40, 40, 100, 180, 150, 130};

		// Reset is held low from the start and released on a rising edge.
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The register must come out of reset holding its documented value.
		cur_modulus = MODULUS_RESET;
		read_modulus(readback);
		if (readback !== {1'b0, MODULUS_RESET})
			note_failure("modulus after reset", {1'b0, MODULUS_RESET}, readback);

		// Directed table: extremes of both operands, every mode, zero exponent, full-width
		// exponent, and the inverse of zero.
		foreach (DIRECTED_ROWS[i])
			offer_item(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].a, DIRECTED_ROWS[i].b,
				DIRECTED_ROWS[i].e, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);

		// Random items, one batch per modulus setting. The modulus only changes once the
		// block has handed back everything it owes.
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph != 0) begin
				drain_results();
				write_modulus(plan_modulus[ph]);
			end
			for (int n = 0; n < plan_items[ph]; n++) begin
				// Now and then the sender holds off until the block has emptied out.
				if ($urandom_range(99) == 0)
					drain_results();
				op = 3'($urandom_range(7));
				offer_item(op, pick_operand(cur_modulus), pick_operand(cur_modulus),
					pick_exponent(cur_modulus), 1'b0, '0);
			end
		end

		drain_results();
		// Extra quiet time to catch any stray result.
		repeat (300) @(posedge clk);

		$display("Covered %0d items under %0d modulus settings (0, 1, 2, 3, 2^31-1, %0d, %0d"
			, items_sent, PHASES, plan_modulus[10], plan_modulus[11]);
		$display("and others); %0d results checked; per mode red..div: %0d %0d %0d %0d %0d %0d %0d %0d",
			results_seen, mode_count[0], mode_count[1], mode_count[2], mode_count[3],
			mode_count[4], mode_count[5], mode_count[6], mode_count[7]);

		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
